// ===== rtl/core/mftt_pkg.sv =====
package mftt_pkg;

	localparam int MOTOR_SLOTS     = 8;
	localparam int SLOT_W          = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;
	localparam int COUNTS_PER_TURN = 8192;
	localparam int CPT_SHIFT       = $clog2(COUNTS_PER_TURN);
	localparam int POS_W           = 46;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 32;

	localparam logic signed [15:0] HALF_TURN     = 16'sd4096;
	localparam logic [10:0]        ID_BASE_RESET = 11'h201;
	localparam logic [31:0]        TIMEOUT_RESET = 32'd100;

	// item modes
	localparam logic [1:0] MODE_FRAME = 2'd0;
	localparam logic [1:0] MODE_RESET = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;

	// result status codes
	localparam logic [1:0] ST_IGNORED = 2'd0;
	localparam logic [1:0] ST_FRAME   = 2'd1;
	localparam logic [1:0] ST_RESET   = 2'd2;
	localparam logic [1:0] ST_QUERY   = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ID_BASE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd1;

	// one slot of the feedback memory; baseline angle always equals angle, so it is not kept
	typedef struct packed {
		logic        seen;
		logic [31:0] stamp;
		logic [31:0] frames;
		logic [31:0] turns;
		logic [7:0]  temp;
		logic [15:0] torque;
		logic [15:0] speed;
		logic [15:0] angle;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// decoded item travelling down the pipe
	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] slot;
		logic [63:0]       data;
		logic [31:0]       now;
	} op_t;

endpackage

// ===== rtl/core/mftt_ram.sv =====
module mftt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/mftt_upd.sv =====
module mftt_upd import mftt_pkg::*; (
	input  op_t    op,
	input  entry_t cur,
	output entry_t nxt,
	output logic   we
);

	logic [15:0]        new_angle;
	logic signed [15:0] delta;

	assign new_angle = op.data[63:48];
	assign delta     = signed'(new_angle - cur.angle);

	always_comb begin
		nxt = cur;
		we  = 1'b0;
		unique case (op.status) inside
			ST_FRAME: begin
				we         = 1'b1;
				nxt.angle  = new_angle;
				nxt.speed  = op.data[47:32];
				nxt.torque = op.data[31:16];
				nxt.temp   = op.data[15:8];
				nxt.stamp  = op.now;
				nxt.frames = cur.frames + 32'd1;
				nxt.seen   = 1'b1;
				// first frame only sets the baseline
				if (cur.seen) begin
					if (delta > HALF_TURN) begin
						nxt.turns = cur.turns - 32'd1;
					end else if (delta < -HALF_TURN) begin
						nxt.turns = cur.turns + 32'd1;
					end
				end
			end
			ST_RESET: begin
				we        = 1'b1;
				nxt.turns = '0;
			end
			ST_QUERY, ST_IGNORED: begin
				we = 1'b0;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/core/motor_feedback_turn_tracker.sv =====
// Channel   Handshake         Payload
// ------    ---------         -------
// item      start / busy      mode, frame_id, frame_data, motor_select, now_ms
// result    done (1 cycle)    status, slot, angle, speed, torque, temperature,
//                             turns, position, frame_count, timed_out
// config    cfg_we            cfg_index, cfg_wdata
//
// Every item passes from transfer to the done strobe through slot decode and memory
// read, read-modify-write of the slot entry, then position and timeout.
// busy is high while the item is in stage 1 or stage 2, so one item is at work at a
// time; the next item may be taken in the cycle that shows done.
// arst_n clears the pipeline valid bits and the per-slot valid bits and resets the
// config registers; a slot not yet written reads as all zero. The receiver cannot stall.
module motor_feedback_turn_tracker import mftt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              mode,
	input  logic [10:0]             frame_id,
	input  logic [63:0]             frame_data,
	input  logic [2:0]              motor_select,
	input  logic [31:0]             now_ms,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_wdata,
	output logic                    done,
	output logic [1:0]              status,
	output logic [2:0]              slot,
	output logic [15:0]             angle,
	output logic signed [15:0]      speed,
	output logic signed [15:0]      torque,
	output logic [7:0]              temperature,
	output logic signed [31:0]      turns,
	output logic signed [POS_W-1:0] position,
	output logic [31:0]             frame_count,
	output logic                    timed_out
);

	// configuration
	logic [10:0] id_base_q;
	logic [31:0] timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_base_q <= ID_BASE_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ID_BASE: id_base_q <= cfg_wdata[10:0];
				REG_TIMEOUT: timeout_q <= cfg_wdata;
				default:     ;
			endcase
		end
	end

	// item decode; the window test is a borrow check plus a range compare
	logic        accept;
	logic [11:0] id_diff;
	logic        in_window;
	logic        sel_ok;
	op_t         dec;

	assign accept    = start && !busy;
	assign id_diff   = {1'b0, frame_id} - {1'b0, id_base_q};
	assign in_window = !id_diff[11] && (id_diff[10:0] < 11'(MOTOR_SLOTS));
	assign sel_ok    = {1'b0, motor_select} < 4'(MOTOR_SLOTS);

	always_comb begin
		dec.status = ST_IGNORED;
		dec.slot   = '0;
		dec.data   = frame_data;
		dec.now    = now_ms;
		unique case (mode)
			MODE_FRAME: begin
				if (in_window) begin
					dec.status = ST_FRAME;
					dec.slot   = id_diff[SLOT_W-1:0];
				end
			end
			MODE_RESET: begin
				if (sel_ok) begin
					dec.status = ST_RESET;
					dec.slot   = motor_select[SLOT_W-1:0];
				end
			end
			MODE_QUERY: begin
				if (sel_ok) begin
					dec.status = ST_QUERY;
					dec.slot   = motor_select[SLOT_W-1:0];
				end
			end
			default: dec.status = ST_IGNORED;
		endcase
	end

	// stage 1: entry arrives from memory, updated and written back
	logic                   v_s1;
	op_t                    op_s1;
	logic [ENTRY_W-1:0]     rd_data;
	logic [MOTOR_SLOTS-1:0] valid_q;
	entry_t                 cur_ent;
	entry_t                 nxt_ent;
	logic                   upd_we;
	logic                   wr_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= dec;
		end
	end

	mftt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MOTOR_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(op_s1.slot),
		.wdata(nxt_ent),
		.raddr(dec.slot),
		.rdata(rd_data)
	);

	// a slot never written reads as its reset value of zero
	assign cur_ent = valid_q[op_s1.slot] ? entry_t'(rd_data) : '0;

	mftt_upd u_upd (
		.op (op_s1),
		.cur(cur_ent),
		.nxt(nxt_ent),
		.we (upd_we)
	);

	assign wr_en = v_s1 && upd_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[op_s1.slot] <= 1'b1;
		end
	end

	// stage 2: position and timeout from the updated entry
	logic              v_s2;
	logic [1:0]        st_s2;
	logic [SLOT_W-1:0] slot_s2;
	entry_t            ent_s2;
	logic [31:0]       now_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			st_s2   <= op_s1.status;
			slot_s2 <= op_s1.slot;
			ent_s2  <= nxt_ent;
			now_s2  <= op_s1.now;
		end
	end

	logic [POS_W-1:0] pos_c;
	logic [31:0]      elapsed;
	logic             tmo_c;

	// turns * COUNTS_PER_TURN is a shift of the sign-extended count
	assign pos_c   = (POS_W'(signed'(ent_s2.turns)) << CPT_SHIFT) + POS_W'(ent_s2.angle);
	assign elapsed = now_s2 - ent_s2.stamp;
	assign tmo_c   = ent_s2.seen && (elapsed > timeout_q);

	// result registers
	logic                    done_q;
	logic [1:0]              status_q;
	logic [2:0]              slot_q;
	logic [15:0]             angle_q;
	logic signed [15:0]      speed_q;
	logic signed [15:0]      torque_q;
	logic [7:0]              temp_q;
	logic signed [31:0]      turns_q;
	logic signed [POS_W-1:0] pos_q;
	logic [31:0]             count_q;
	logic                    tmo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			if (st_s2 == ST_IGNORED) begin
				status_q <= ST_IGNORED;
				slot_q   <= '0;
				angle_q  <= '0;
				speed_q  <= '0;
				torque_q <= '0;
				temp_q   <= '0;
				turns_q  <= '0;
				pos_q    <= '0;
				count_q  <= '0;
				tmo_q    <= 1'b0;
			end else begin
				status_q <= st_s2;
				slot_q   <= 3'(slot_s2);
				angle_q  <= ent_s2.angle;
				speed_q  <= signed'(ent_s2.speed);
				torque_q <= signed'(ent_s2.torque);
				temp_q   <= ent_s2.temp;
				turns_q  <= signed'(ent_s2.turns);
				pos_q    <= signed'(pos_c);
				count_q  <= ent_s2.frames;
				tmo_q    <= tmo_c;
			end
		end
	end

	assign busy        = v_s1 || v_s2;
	assign done        = done_q;
	assign status      = status_q;
	assign slot        = slot_q;
	assign angle       = angle_q;
	assign speed       = speed_q;
	assign torque      = torque_q;
	assign temperature = temp_q;
	assign turns       = turns_q;
	assign position    = pos_q;
	assign frame_count = count_q;
	assign timed_out   = tmo_q;

endmodule

// ===== rtl/core/mftt_chk.sv =====
module mftt_chk import mftt_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    done,
	input logic [1:0]              status,
	input logic [2:0]              slot,
	input logic signed [31:0]      turns,
	input logic signed [POS_W-1:0] position,
	input logic [31:0]             frame_count,
	input logic                    timed_out
);

	// each transfer must be followed by its done strobe at a set point
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("result not delivered three cycles after transfer");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done shown while still busy");

	a_ignored_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_IGNORED) |->
			(slot == 3'd0 && turns == 32'sd0 && frame_count == 32'd0 &&
			 position == '0 && !timed_out))
		else $error("ignored item carries non-zero fields");

	a_reset_turns: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_RESET) |-> (turns == 32'sd0))
		else $error("turn count not cleared by reset item");

endmodule

bind motor_feedback_turn_tracker mftt_chk u_mftt_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.slot       (slot),
	.turns      (turns),
	.position   (position),
	.frame_count(frame_count),
	.timed_out  (timed_out)
);
